// ===== rtl/joint_iir_filter_bank_defines.svh =====
// ----------------------------------------------------------------------------
// Joint IIR filter bank assertion macros
// Checks are compiled unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JOINT_IIR_FILTER_BANK_DEFINES_SVH
`define JOINT_IIR_FILTER_BANK_DEFINES_SVH
`ifndef SYNTH
`define JIF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JIF_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JIF_ASSERT(lbl, clk, rst, prop, msg)
`define JIF_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/jif_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint IIR filter bank package
// Payload types, history row layout and the Q2.16 coefficient table.
// ----------------------------------------------------------------------------
package jif_pkg;

   localparam int JOINTS_DEFAULT = 32;
   localparam int NUM_AXES       = 3;
   localparam int NUM_FILT       = 3;
   localparam int NUM_TAPS       = 9;
   localparam int LAST_TAP       = NUM_TAPS - 1;
   localparam int LAST_FILT      = NUM_FILT - 1;
   localparam int COEF_W         = 19;

   localparam logic [1:0] LEVEL_SOFT   = 2'd0;
   localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
   localparam logic [1:0] LEVEL_HARD   = 2'd2;
   localparam logic [1:0] LEVEL_UNUSED = 2'd3;

   typedef struct packed {
      logic [4:0]         joint_index;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [4:0]         joint_tag;
      logic signed [31:0] smooth_x;
      logic signed [31:0] smooth_y;
      logic signed [31:0] smooth_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
   } rsp_type;

   typedef struct packed {
      logic [3:0][23:0]      raw;
      logic [2:0][3:0][31:0] y;
   } axis_hist_type;

   typedef axis_hist_type [2:0] row_type;

   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [1:0] filt;
   } mac_ctl_type;

   // feedback taps stored negated so every product is added
   localparam logic signed [COEF_W-1:0] COEF_TAB [3][3][9] = '{
      '{
         '{19'sd12134, 19'sd9065, 19'sd11448, 19'sd6859, 19'sd3043,
           19'sd85082, -19'sd95906, 19'sd46573, -19'sd13296},
         '{19'sd17776, 19'sd8675, -19'sd3193, -19'sd11688, -19'sd11570,
           19'sd19133, -19'sd33454, 19'sd1021, -19'sd19},
         '{19'sd7203, -19'sd8448, -19'sd2442, 19'sd1416, 19'sd2271,
           19'sd54231, -19'sd53155, 19'sd23140, -19'sd4325}
      },
      '{
         '{19'sd10002, 19'sd2186, 19'sd5096, 19'sd4372, 19'sd911,
           19'sd114440, -19'sd113732, 19'sd53954, -19'sd11754},
         '{19'sd12935, -19'sd371, -19'sd2109, -19'sd7205, -19'sd3249,
           19'sd64689, -19'sd50953, 19'sd14463, -19'sd1844},
         '{-19'sd5214, 19'sd9114, -19'sd3140, -19'sd206, -19'sd554,
           19'sd102959, -19'sd95631, 19'sd47014, -19'sd9752}
      },
      '{
         '{19'sd9181, -19'sd2253, 19'sd2975, 19'sd654, 19'sd56,
           19'sd125734, -19'sd104395, 19'sd38926, -19'sd5339},
         '{-19'sd10113, 19'sd11419, -19'sd1172, -19'sd151, 19'sd17,
           19'sd134840, -19'sd121812, 19'sd52546, -19'sd8590},
         '{-19'sd4843, 19'sd8858, -19'sd3362, -19'sd478, -19'sd175,
           19'sd106711, -19'sd92980, 19'sd40786, -19'sd7112}
      }
   };

endpackage

// ===== rtl/jif_mac.sv =====
// ----------------------------------------------------------------------------
// Joint IIR filter bank multiply-accumulate lane
// Registered product, wide accumulator, round and saturate per filter.
// ----------------------------------------------------------------------------
module jif_mac
   import jif_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctl_type              ctl,
   input  logic signed [31:0]       operand,
   input  logic signed [COEF_W-1:0] coef,
   output logic [2:0][31:0]         res
);

   localparam int PW = 32 + COEF_W;
   localparam int AW = PW + 5;

   mac_ctl_type        ctl_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] sum_in;
   logic signed [AW-1:0] rnd;
   logic signed [AW-17:0] shf;
   logic signed [31:0]   sat;
   logic [2:0][31:0]     res_ff;

   always_comb begin
      sum_in = (ctl_ff.first ? '0 : acc_ff) + AW'(prod_ff);
      rnd    = sum_in + AW'(32768);
      shf    = rnd[AW-1:16];
      if (shf > (AW-16)'(64'sd2147483647)) begin
         sat = 32'sh7fffffff;
      end else if (shf < -(AW-16)'(64'sd2147483648)) begin
         sat = 32'sh80000000;
      end else begin
         sat = shf[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= operand * coef;
      if (ctl_ff.valid) begin
         acc_ff <= sum_in;
         if (ctl_ff.last) begin
            res_ff[ctl_ff.filt] <= sat;
         end
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/joint_iir_filter_bank.sv =====
// ----------------------------------------------------------------------------
// Joint IIR filter bank
// Per joint and axis fourth-order smoother, velocity and acceleration filters.
//
//   port group  dir  handshake        payload
//   req_*       in   valid / stall    req_type
//   rsp_*       out  valid / stall    rsp_type
//   csr_*       in   valid / ready    filter level, 2 bits
//
// An in-range request is picked up, its row read, 27 products run on three
// axis lanes (9 taps x 3 filters), a drain step and a write-back follow. An
// out-of-range joint goes straight to write-back. One request is buffered
// while another is in work. Reset clears the per-joint valid bits at once.
// The write-back holds while the result register is full and stalled.
// ----------------------------------------------------------------------------
`include "joint_iir_filter_bank_defines.svh"

module joint_iir_filter_bank
   import jif_pkg::*;
#(
   parameter int JOINTS = JOINTS_DEFAULT
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data
);

   localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_MAC  = 4'b0100,
      ST_WB   = 4'b1000
   } state_type;

   state_type      state_ff;
   logic [1:0]     level_ff;
   logic           buf_valid_ff;
   req_type        buf_data_ff;
   req_type        item_ff;
   logic           in_range_ff;
   logic [AW-1:0]  addr_ff;
   logic [AW-1:0]  buf_addr;
   logic           buf_in_range;
   logic [JOINTS-1:0] valid_ff;
   row_type        mem [JOINTS];
   row_type        mem_rd_ff;
   row_type        hist_ff;
   row_type        row_in;
   logic [3:0]     tap_ff;
   logic [1:0]     filt_ff;
   logic           drain_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;
   logic           take;
   logic           wb_go;
   logic [3:0]     tap_m1;
   mac_ctl_type    ctl;
   logic signed [23:0] pos [3];
   logic signed [31:0] operand [3];
   logic [2:0][31:0]   res [3];

   assign req_stall = buf_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign buf_addr     = AW'(buf_data_ff.joint_index);
   assign buf_in_range = 32'(buf_data_ff.joint_index) < JOINTS;
   assign take         = (state_ff == ST_IDLE) && buf_valid_ff;
   assign wb_go        = (state_ff == ST_WB) && (!rsp_valid_ff || !rsp_stall);
   assign tap_m1       = tap_ff - 4'd1;

   assign pos[0] = item_ff.pos_x;
   assign pos[1] = item_ff.pos_y;
   assign pos[2] = item_ff.pos_z;

   assign ctl.valid = (state_ff == ST_MAC) && !drain_ff;
   assign ctl.first = tap_ff == 4'd0;
   assign ctl.last  = tap_ff == 4'(LAST_TAP);
   assign ctl.filt  = filt_ff;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (tap_ff == 4'd0) begin
            operand[a] = 32'(pos[a]);
         end else if (tap_ff <= 4'd4) begin
            operand[a] = 32'(signed'(hist_ff[a].raw[tap_m1[1:0]]));
         end else begin
            operand[a] = hist_ff[a].y[filt_ff][tap_m1[1:0]];
         end
         row_in[a].raw = {hist_ff[a].raw[2:0], pos[a]};
         for (int f = 0; f < NUM_FILT; f++) begin
            row_in[a].y[f] = {hist_ff[a].y[f][2:0], res[a][f]};
         end
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      jif_mac u_mac (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .operand (operand[a]),
         .coef    (COEF_TAB[level_ff][filt_ff][tap_ff]),
         .res     (res[a])
      );
   end

   always_ff @(posedge clock) begin
      if (take && buf_in_range) begin
         mem_rd_ff <= mem[buf_addr];
      end
      if (wb_go && in_range_ff) begin
         mem[addr_ff] <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= LEVEL_SOFT;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         drain_ff     <= 1'b0;
         tap_ff       <= 4'd0;
         filt_ff      <= 2'd0;
      end else begin
         if (csr_valid && csr_data != LEVEL_UNUSED) begin
            level_ff <= csr_data;
         end
         if (req_valid && !req_stall) begin
            buf_valid_ff <= 1'b1;
            buf_data_ff  <= req_data;
         end
         if (rsp_valid_ff && !rsp_stall && !wb_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (buf_valid_ff) begin
                  buf_valid_ff <= 1'b0;
                  item_ff      <= buf_data_ff;
                  addr_ff      <= buf_addr;
                  in_range_ff  <= buf_in_range;
                  state_ff     <= buf_in_range ? ST_READ : ST_WB;
               end
            end
            ST_READ: begin
               hist_ff  <= valid_ff[addr_ff] ? mem_rd_ff : '0;
               tap_ff   <= 4'd0;
               filt_ff  <= 2'd0;
               drain_ff <= 1'b0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               if (drain_ff) begin
                  drain_ff <= 1'b0;
                  state_ff <= ST_WB;
               end else if (tap_ff == 4'(LAST_TAP)) begin
                  tap_ff <= 4'd0;
                  if (filt_ff == 2'(LAST_FILT)) begin
                     drain_ff <= 1'b1;
                  end else begin
                     filt_ff <= filt_ff + 2'd1;
                  end
               end else begin
                  tap_ff <= tap_ff + 4'd1;
               end
            end
            ST_WB: begin
               if (wb_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.joint_tag <= item_ff.joint_index;
                  rsp_data_ff.smooth_x  <= in_range_ff ? res[0][0] : '0;
                  rsp_data_ff.smooth_y  <= in_range_ff ? res[1][0] : '0;
                  rsp_data_ff.smooth_z  <= in_range_ff ? res[2][0] : '0;
                  rsp_data_ff.vel_x     <= in_range_ff ? res[0][1] : '0;
                  rsp_data_ff.vel_y     <= in_range_ff ? res[1][1] : '0;
                  rsp_data_ff.vel_z     <= in_range_ff ? res[2][1] : '0;
                  rsp_data_ff.acc_x     <= in_range_ff ? res[0][2] : '0;
                  rsp_data_ff.acc_y     <= in_range_ff ? res[1][2] : '0;
                  rsp_data_ff.acc_z     <= in_range_ff ? res[2][2] : '0;
                  if (in_range_ff) begin
                     valid_ff[addr_ff] <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `JIF_ASSERT_RST(a_reset_idle, clock, reset |=> state_ff == ST_IDLE && !rsp_valid_ff, "reset state")
   `JIF_ASSERT(a_wb_result, clock, reset, wb_go |=> rsp_valid_ff, "write-back lost result")
   `JIF_ASSERT(a_wb_valid, clock, reset, (wb_go && in_range_ff) |=> valid_ff[$past(addr_ff)], "row not marked")
   `JIF_ASSERT(a_mac_count, clock, reset, ctl.valid |-> tap_ff <= 4'(LAST_TAP) && filt_ff <= 2'(LAST_FILT), "tap count")
   `JIF_ASSERT(a_take_empty, clock, reset, (state_ff == ST_READ) |-> in_range_ff, "read for bad joint")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Joint IIR filter bank testbench
// Drives joint samples with random gaps and output stalls, predicts the
// smoother, velocity and acceleration outputs per joint and axis, and checks
// every result in order. The filter level is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
   import jif_pkg::*;
();

   localparam int NJ = 32;

   class filter_scoreboard;
      int unsigned fail_count;
      rsp_type     pending[$];
      logic [1:0]  level;
      logic signed [23:0] raw_hist[NJ][3][4];
      logic signed [31:0] out_hist[NJ][3][3][4];
      // published Q2.16 taps: b0..b4, a1..a4
      int signed   taps[3][3][9];

      function new();
         taps = '{
            '{'{12134, 9065, 11448, 6859, 3043, -85082, 95906, -46573, 13296},
              '{17776, 8675, -3193, -11688, -11570, -19133, 33454, -1021, 19},
              '{7203, -8448, -2442, 1416, 2271, -54231, 53155, -23140, 4325}},
            '{'{10002, 2186, 5096, 4372, 911, -114440, 113732, -53954, 11754},
              '{12935, -371, -2109, -7205, -3249, -64689, 50953, -14463, 1844},
              '{-5214, 9114, -3140, -206, -554, -102959, 95631, -47014, 9752}},
            '{'{9181, -2253, 2975, 654, 56, -125734, 104395, -38926, 5339},
              '{-10113, 11419, -1172, -151, 17, -134840, 121812, -52546, 8590},
              '{-4843, 8858, -3362, -478, -175, -106711, 92980, -40786, 7112}}};
         fail_count = 0;
         level = LEVEL_SOFT;
         foreach (raw_hist[j, a, k]) raw_hist[j][a][k] = '0;
         foreach (out_hist[j, a, f, k]) out_hist[j][a][f][k] = '0;
      endfunction

      function void write_level(logic [1:0] v);
         if (v != LEVEL_UNUSED) level = v;
      endfunction

      function logic signed [31:0] filter_tap(int j, int a, int f,
                                              logic signed [23:0] x0);
         longint acc;
         longint q;
         acc = longint'(taps[level][f][0]) * longint'(x0);
         for (int k = 0; k < 4; k++) begin
            acc += longint'(taps[level][f][1+k]) * longint'(raw_hist[j][a][k]);
            acc -= longint'(taps[level][f][5+k]) * longint'(out_hist[j][a][f][k]);
         end
         q = (acc + 32768) >>> 16;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q[31:0];
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         logic signed [23:0] x[3];
         logic signed [31:0] y[3][3];
         int j;
         j = int'(r.joint_index);
         x[0] = r.pos_x; x[1] = r.pos_y; x[2] = r.pos_z;
         for (int a = 0; a < 3; a++) begin
            for (int f = 0; f < 3; f++) begin
               y[a][f] = filter_tap(j, a, f, x[a]);
               for (int k = 3; k > 0; k--) out_hist[j][a][f][k] = out_hist[j][a][f][k-1];
               out_hist[j][a][f][0] = y[a][f];
            end
            for (int k = 3; k > 0; k--) raw_hist[j][a][k] = raw_hist[j][a][k-1];
            raw_hist[j][a][0] = x[a];
         end
         e.joint_tag = r.joint_index;
         e.smooth_x = y[0][0]; e.smooth_y = y[1][0]; e.smooth_z = y[2][0];
         e.vel_x = y[0][1]; e.vel_y = y[1][1]; e.vel_z = y[2][1];
         e.acc_x = y[0][2]; e.acc_y = y[1][2]; e.acc_z = y[2][2];
         pending.insert(pending.size(), e);
      endfunction

      function void report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         fail_count++;
      endfunction

      function void check_result(rsp_type g);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("mismatch: unexpected result for joint %0d", g.joint_tag);
            fail_count++;
            return;
         end
         e = pending.pop_front();
         if (g.joint_tag != e.joint_tag)
            report("joint_tag", longint'(g.joint_tag), longint'(e.joint_tag));
         if (g.smooth_x != e.smooth_x)
            report("smooth_x", longint'(g.smooth_x), longint'(e.smooth_x));
         if (g.smooth_y != e.smooth_y)
            report("smooth_y", longint'(g.smooth_y), longint'(e.smooth_y));
         if (g.smooth_z != e.smooth_z)
            report("smooth_z", longint'(g.smooth_z), longint'(e.smooth_z));
         if (g.vel_x != e.vel_x) report("vel_x", longint'(g.vel_x), longint'(e.vel_x));
         if (g.vel_y != e.vel_y) report("vel_y", longint'(g.vel_y), longint'(e.vel_y));
         if (g.vel_z != e.vel_z) report("vel_z", longint'(g.vel_z), longint'(e.vel_z));
         if (g.acc_x != e.acc_x) report("acc_x", longint'(g.acc_x), longint'(e.acc_x));
         if (g.acc_y != e.acc_y) report("acc_y", longint'(g.acc_y), longint'(e.acc_y));
         if (g.acc_z != e.acc_z) report("acc_z", longint'(g.acc_z), longint'(e.acc_z));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data = '0;

   filter_scoreboard sb = new();
   bit   long_hold = 1'b0;

   joint_iir_filter_bank uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (600) @(negedge clock);
            long_hold = 1'b0;
         end
         n = $urandom_range(0, 4);
         if ($urandom_range(0, 3) == 0) n = 0;
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   task automatic send_request(req_type r, bit no_gap);
      int n;
      n = no_gap ? 0 : $urandom_range(0, 4);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_level(logic [1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_level(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type rand_request(int jmax);
      req_type r;
      int k;
      r.joint_index = 5'($urandom_range(0, jmax));
      k = $urandom_range(0, 9);
      r.pos_x = (k == 0) ? 24'sh7fffff : (k == 1) ? 24'sh800000 : 24'($urandom);
      r.pos_y = (k == 2) ? 24'sh7fffff : (k == 3) ? 24'sh800000 : 24'($urandom);
      r.pos_z = (k == 4) ? 24'sh7fffff : (k == 5) ? 24'sh800000 : 24'($urandom);
      if (k >= 6) begin
         // smooth trajectories reach the low-pass steady state
         r.pos_x = 24'(int'($urandom_range(0, 4000)) - 2000 + 32'sh10000);
      end
      return r;
   endfunction

   initial begin
      req_type r;
      static logic [1:0] levels[5] = '{LEVEL_MEDIUM, LEVEL_HARD, LEVEL_UNUSED,
                                       LEVEL_SOFT, LEVEL_HARD};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, step inputs to saturate the filters, joints 0 and 31 plus every fourth joint from 1
      for (int i = 0; i < 12; i++) begin
         r.joint_index = (i < 6) ? 5'd0 : 5'd31;
         r.pos_x = (i % 2) ? 24'sh800000 : 24'sh7fffff;
         r.pos_y = (i % 2) ? 24'sh7fffff : 24'sh800000;
         r.pos_z = (i < 3) ? 24'sh7fffff : 24'sh000000;
         send_request(r, 1'b0);
      end
      for (int i = 0; i < 8; i++) begin
         r.joint_index = 5'(i * 4 + 1);
         r.pos_x = 24'sh000001; r.pos_y = -24'sh1; r.pos_z = 24'sh555555;
         send_request(r, 1'b0);
      end
      drain();

      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            write_level(levels[p-1]);
            drain();
         end
         if (p == 2) begin
            long_hold = 1'b1;
            for (int i = 0; i < 12; i++) send_request(rand_request(31), 1'b1);
         end
         for (int i = 0; i < 230; i++) begin
            send_request(rand_request((i % 3 == 0) ? 31 : 3), 1'b0);
            if (i == 100) drain();
         end
         drain();
      end
      if (sb.fail_count == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
